// ----- rtl/core/iirl_pkg.sv -----
// Shared widths, request and status codes, and controller/datapath types for the indexed list.
package iirl_pkg;

  // Field widths of one item and one result.
  localparam int unsigned REQ_W = 3;
  localparam int unsigned POS_W = 5;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned LEN_W = 5;

  // Default list capacity.
  localparam int unsigned DEPTH_DEF = 16;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_GET     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REPLACE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_FIN,
    S_CLR,
    S_RESPOND
  } iirl_state_e;

  // Cursor register operations.
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_COUNT,
    CUR_POS,
    CUR_ZERO,
    CUR_INC,
    CUR_DEC
  } iirl_cur_op_e;

  // Read address selection.
  typedef enum logic [1:0] {
    RD_POS,
    RD_CUR_DN,
    RD_CUR_UP
  } iirl_rd_sel_e;

  // Write address and data selection.
  typedef enum logic [1:0] {
    WR_POS_VALUE,
    WR_CUR_RDATA,
    WR_CUR_ZERO
  } iirl_wr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         load_req;
    logic         latch_status;
    logic         rd_en;
    iirl_rd_sel_e rd_sel;
    logic         wr_en;
    iirl_wr_sel_e wr_sel;
    logic         cnt_inc;
    logic         cnt_dec;
    iirl_cur_op_e cur_op;
  } iirl_cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             ok;
    logic             pos_lt_cnt;
    logic             pos_p1_eq_cnt;
    logic             cnt_zero;
    logic             cur_dn_eq_pos;
    logic             cur_p1_eq_cnt;
    logic             cur_p2_eq_cnt;
  } iirl_stat_t;

endpackage

// ----- rtl/core/iirl_ctrl.sv -----
// Controller state machine that sequences each list request over the datapath.
module iirl_ctrl import iirl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  output logic       done_o,
  input  iirl_stat_t stat_i,
  output iirl_cmd_t  cmd_o
);

  iirl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A new item may be taken while idle or while the previous result is shown.
  assign busy   = !((state_q == S_IDLE) || (state_q == S_RESPOND));
  assign done_o = (state_q == S_RESPOND);

  // Next state and datapath commands.
  always_comb begin
    state_d            = state_q;
    cmd_o.load_req     = 1'b0;
    cmd_o.latch_status = 1'b0;
    cmd_o.rd_en        = 1'b0;
    cmd_o.rd_sel       = RD_POS;
    cmd_o.wr_en        = 1'b0;
    cmd_o.wr_sel       = WR_POS_VALUE;
    cmd_o.cnt_inc      = 1'b0;
    cmd_o.cnt_dec      = 1'b0;
    cmd_o.cur_op       = CUR_HOLD;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_CHECK;
        end
      end

      S_CHECK: begin
        cmd_o.latch_status = 1'b1;
        state_d            = S_RESPOND;
        if (stat_i.ok) begin
          case (stat_i.req)
            REQ_GET: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_POS;
            end
            REQ_REPLACE: begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = WR_POS_VALUE;
            end
            REQ_INSERT: begin
              // Appending at the end needs no shift.
              if (!stat_i.pos_lt_cnt) begin
                state_d = S_INS_FIN;
              end else begin
                cmd_o.cur_op = CUR_COUNT;
                state_d      = S_SHIFT_RD;
              end
            end
            REQ_REMOVE: begin
              // Removing the last entry needs no shift.
              if (stat_i.pos_p1_eq_cnt) begin
                cmd_o.cnt_dec = 1'b1;
              end else begin
                cmd_o.cur_op = CUR_POS;
                state_d      = S_SHIFT_RD;
              end
            end
            REQ_CLEAR: begin
              if (!stat_i.cnt_zero) begin
                cmd_o.cur_op = CUR_ZERO;
                state_d      = S_CLR;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SHIFT_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = (stat_i.req == REQ_INSERT) ? RD_CUR_DN : RD_CUR_UP;
        state_d      = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_CUR_RDATA;
        if (stat_i.req == REQ_INSERT) begin
          if (stat_i.cur_dn_eq_pos) begin
            state_d = S_INS_FIN;
          end else begin
            cmd_o.cur_op = CUR_DEC;
            state_d      = S_SHIFT_RD;
          end
        end else begin
          if (stat_i.cur_p2_eq_cnt) begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = S_RESPOND;
          end else begin
            cmd_o.cur_op = CUR_INC;
            state_d      = S_SHIFT_RD;
          end
        end
      end

      S_INS_FIN: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_POS_VALUE;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_RESPOND;
      end

      S_CLR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_CUR_ZERO;
        if (stat_i.cur_p1_eq_cnt) begin
          state_d = S_RESPOND;
        end else begin
          cmd_o.cur_op = CUR_INC;
        end
      end

      S_RESPOND: begin
        if (start) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_CHECK;
        end else begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // An accepted item always starts with its range check.
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_CHECK))
    else $error("accepted item did not enter the check state");

  // Each result strobe lasts a single cycle.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // Every shift read is followed by its write.
  a_shift_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_RD) |=> (state_q == S_SHIFT_WR))
    else $error("shift read not followed by its write");

endmodule

// ----- rtl/core/iirl_dpath.sv -----
// Datapath of the indexed list: request registers, entry memory, count, cursor and checks.
module iirl_dpath import iirl_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  iirl_cmd_t               cmd_i,
  output iirl_stat_t              stat_o,
  output logic [ST_W-1:0]         status_o,
  output logic signed [VAL_W-1:0] read_value_o,
  output logic [LEN_W-1:0]        length_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned EW = XW + 1;

  logic [REQ_W-1:0]        req_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] val_q;
  logic [CW-1:0]           count_q;
  logic [AW-1:0]           cursor_q, cursor_d;
  logic [ST_W-1:0]         status_q;
  logic signed [VAL_W-1:0] rdata_q;
  logic signed [VAL_W-1:0] mem [DEPTH];

  logic [EW-1:0]           pos_e, cnt_e, cur_e;
  logic [AW-1:0]           pos_a, rd_addr, wr_addr;
  logic signed [VAL_W-1:0] wr_data;
  logic                    pos_lt_cnt, pos_le_cnt, full;
  logic [ST_W-1:0]         st_code;

  // Request capture; the code is reset since the controller branches on it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= REQ_GET;
    end else if (cmd_i.load_req) begin
      req_q <= req_type_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      pos_q <= position_i;
      val_q <= value_i;
    end
  end

  // Common-width views for the comparisons.
  assign pos_e = EW'(pos_q);
  assign cnt_e = EW'(count_q);
  assign cur_e = EW'(cursor_q);
  assign pos_a = pos_e[AW-1:0];

  assign pos_lt_cnt = (pos_e < cnt_e);
  assign pos_le_cnt = (pos_e <= cnt_e);
  assign full       = (cnt_e == EW'(DEPTH));

  // Range and capacity check on the captured item.
  always_comb begin
    st_code = ST_DONE;
    case (req_q)
      REQ_GET, REQ_REPLACE, REQ_REMOVE: begin
        if (!pos_lt_cnt) begin
          st_code = ST_RANGE;
        end
      end
      REQ_INSERT: begin
        if (!pos_le_cnt) begin
          st_code = ST_RANGE;
        end else if (full) begin
          st_code = ST_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat_o.req           = req_q;
  assign stat_o.ok            = (st_code == ST_DONE);
  assign stat_o.pos_lt_cnt    = pos_lt_cnt;
  assign stat_o.pos_p1_eq_cnt = ((pos_e + EW'(1)) == cnt_e);
  assign stat_o.cnt_zero      = (count_q == '0);
  assign stat_o.cur_dn_eq_pos = ((cur_e - EW'(1)) == pos_e);
  assign stat_o.cur_p1_eq_cnt = ((cur_e + EW'(1)) == cnt_e);
  assign stat_o.cur_p2_eq_cnt = ((cur_e + EW'(2)) == cnt_e);

  // Status of the current item, taken while it is checked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_DONE;
    end else if (cmd_i.latch_status) begin
      status_q <= st_code;
    end
  end

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_q <= count_q - CW'(1);
    end
  end

  // Cursor that walks the entries during shifts and clears.
  always_comb begin
    case (cmd_i.cur_op)
      CUR_HOLD:  cursor_d = cursor_q;
      CUR_COUNT: cursor_d = cnt_e[AW-1:0];
      CUR_POS:   cursor_d = pos_a;
      CUR_ZERO:  cursor_d = '0;
      CUR_INC:   cursor_d = cursor_q + AW'(1);
      CUR_DEC:   cursor_d = cursor_q - AW'(1);
      default:   cursor_d = cursor_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else begin
      cursor_q <= cursor_d;
    end
  end

  // Memory address and data selection.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_POS:    rd_addr = pos_a;
      RD_CUR_DN: rd_addr = cursor_q - AW'(1);
      RD_CUR_UP: rd_addr = cursor_q + AW'(1);
      default:   rd_addr = pos_a;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WR_POS_VALUE: begin
        wr_addr = pos_a;
        wr_data = val_q;
      end
      WR_CUR_RDATA: begin
        wr_addr = cursor_q;
        wr_data = rdata_q;
      end
      WR_CUR_ZERO: begin
        wr_addr = cursor_q;
        wr_data = '0;
      end
      default: begin
        wr_addr = pos_a;
        wr_data = val_q;
      end
    endcase
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Result fields.
  assign status_o     = status_q;
  assign read_value_o = ((status_q == ST_DONE) && (req_q == REQ_GET)) ? rdata_q : '0;
  assign length_o     = cnt_e[LEN_W-1:0];

  // The count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above capacity");

  // An insert only grows a list that has room.
  a_inc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> !full)
    else $error("count increment on a full list");

  // A removal never runs on an empty list.
  a_dec_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> (count_q != '0))
    else $error("count decrement on an empty list");

endmodule

// ----- rtl/core/indexed_insert_remove_list_top.sv -----
// Top level of the indexed list: joins the controller and the datapath.
//
// Usage: an item (req_type_i, position_i, value_i) is taken at a rising edge with
// start high and busy low. Exactly one result (status_o, read_value_o, length_o)
// follows, shown for a single cycle while done_o is high; the receiver cannot stall.
// busy is low while idle and during the cycle that shows a result, so the next
// item may be given in that same cycle.
// Insert moves the n - p entries from position p up by one (n = count before the
// request, p = position); remove moves the n - 1 - p entries above p down by one;
// clear writes zero to all n entries; get, replace, errors, full and unused codes
// move no entries. Each moved entry is read and then written back in the shift
// states, and each cleared entry is written once.
// Reset makes the list empty and the block idle; entry contents are not
// cleared and are only read after an insert has written them.
module indexed_insert_remove_list_top import iirl_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    done_o,
  output logic [ST_W-1:0]         status_o,
  output logic signed [VAL_W-1:0] read_value_o,
  output logic [LEN_W-1:0]        length_o
);

  iirl_cmd_t  cmd;
  iirl_stat_t stat;

  // Request sequencer.
  iirl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Storage, count and checks.
  iirl_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .length_o     (length_o)
  );

endmodule

// ----- tb/indexed_insert_remove_list_checker.sv -----
// Checker for the indexed list: predicts each result from the accepted items and compares.
`timescale 1ns / 1ps

module indexed_insert_remove_list_checker import iirl_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    busy,
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    done_i,
  input  logic [ST_W-1:0]         status_i,
  input  logic signed [VAL_W-1:0] read_value_i,
  input  logic [LEN_W-1:0]        length_i,
  output int                      mismatch_count_o,
  output int                      results_pending_o,
  output int                      list_len_o
);

  // One expected result of the list.
  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        length;
  } list_result_t;

  // Shadow copy of the list contents and its length.
  logic signed [VAL_W-1:0] shadow_mem [DEPTH];
  int                      shadow_len;
  list_result_t            expected_results [$];

  initial begin
    mismatch_count_o  = 0;
    results_pending_o = 0;
    list_len_o        = 0;
  end

  // Apply one request to the shadow list and return the result it must give.
  task automatic apply_request(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                               input logic signed [VAL_W-1:0] val,
                               output list_result_t res);
    int idx;
    int ipos;
    ipos           = int'(pos);
    res.status     = ST_DONE;
    res.read_value = '0;
    case (req)
      REQ_GET: begin
        if (ipos >= shadow_len) res.status = ST_RANGE;
        else res.read_value = shadow_mem[ipos];
      end
      REQ_REPLACE: begin
        if (ipos >= shadow_len) res.status = ST_RANGE;
        else shadow_mem[ipos] = val;
      end
      REQ_INSERT: begin
        // The range check wins over the full check.
        if (ipos > shadow_len) begin
          res.status = ST_RANGE;
        end else if (shadow_len >= int'(DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          for (idx = shadow_len; idx > ipos; idx--) shadow_mem[idx] = shadow_mem[idx - 1];
          shadow_mem[ipos] = val;
          shadow_len++;
        end
      end
      REQ_REMOVE: begin
        if (ipos >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          for (idx = ipos; idx + 1 < shadow_len; idx++) shadow_mem[idx] = shadow_mem[idx + 1];
          shadow_len--;
        end
      end
      REQ_CLEAR: begin
        for (idx = 0; idx < shadow_len; idx++) shadow_mem[idx] = '0;
      end
      default: begin
        // Spare request codes leave everything as it is.
      end
    endcase
    res.length = shadow_len[LEN_W-1:0];
  endtask

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    $display("[%0t] list check: %s got 0x%08h, expected 0x%08h", $time, what, got, want);
    mismatch_count_o++;
  endtask

  // Compare the result shown at this edge, then take in the item accepted at it.
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    list_result_t next_res;
    if (!rst_ni) begin
      shadow_len = 0;
      expected_results.delete();
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result without a pending item, status", 32'(status_i), '0);
        end else begin
          want = expected_results.pop_front();
          if (status_i !== want.status)
            report_mismatch("status", 32'(status_i), 32'(want.status));
          if (read_value_i !== want.read_value)
            report_mismatch("read_value", read_value_i, want.read_value);
          if (length_i !== want.length)
            report_mismatch("length", 32'(length_i), 32'(want.length));
        end
      end
      if (start && !busy) begin
        apply_request(req_type_i, position_i, value_i, next_res);
        expected_results.push_back(next_res);
      end
    end
    results_pending_o = expected_results.size();
    list_len_o        = shadow_len;
  end

endmodule

// ----- tb/tb_indexed_insert_remove_list_top.sv -----
// Testbench top for the indexed list: drives items and gives the verdict.
`timescale 1ns / 1ps

module tb_indexed_insert_remove_list_top;
  import iirl_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 2 * DEPTH_DEF + 8;

  // Request codes the block does not define.
  localparam logic [REQ_W-1:0] REQ_SPARE5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

  logic                    clk_i  = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start  = 1'b0;
  logic                    busy;
  logic [REQ_W-1:0]        req_type = '0;
  logic [POS_W-1:0]        position = '0;
  logic signed [VAL_W-1:0] value    = '0;
  logic                    done;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] read_value;
  logic [LEN_W-1:0]        length;
  int                      mismatch_count;
  int                      results_pending;
  int                      list_len;
  int                      cycle_count = 0;

  indexed_insert_remove_list_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type),
    .position_i   (position),
    .value_i      (value),
    .done_o       (done),
    .status_o     (status),
    .read_value_o (read_value),
    .length_o     (length)
  );

  indexed_insert_remove_list_checker checker_inst (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type),
    .position_i        (position),
    .value_i           (value),
    .done_i            (done),
    .status_i          (status),
    .read_value_i      (read_value),
    .length_i          (length),
    .mismatch_count_o  (mismatch_count),
    .results_pending_o (results_pending),
    .list_len_o        (list_len)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** indexed_insert_remove_list_top: FAILED **");
      $finish;
    end
  end

  // Present one item at the falling edge and hold it until the block takes it.
  task automatic send_item(input logic [REQ_W-1:0] req, input int pos,
                           input logic signed [VAL_W-1:0] val);
    @(negedge clk_i);
    start    <= 1'b1;
    req_type <= req;
    position <= pos[POS_W-1:0];
    value    <= val;
    do @(posedge clk_i); while (busy);
  endtask

  // Leave start low for some cycles, with junk on the fields.
  task automatic idle_cycles(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start    <= 1'b0;
      req_type <= REQ_W'($urandom);
      position <= POS_W'($urandom);
      value    <= $urandom;
    end
  endtask

  // Data words, with the extremes showing up often.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // A random item; mostly well-formed against the current length, some noise.
  task automatic send_random_item(input bit fill_phase);
    int roll;
    int pos;
    logic [REQ_W-1:0] req;
    roll = $urandom_range(0, 99);
    if (fill_phase) begin
      if (roll < 50) req = REQ_INSERT;
      else if (roll < 65) req = REQ_REMOVE;
      else if (roll < 80) req = REQ_GET;
      else if (roll < 90) req = REQ_REPLACE;
      else if (roll < 92) req = REQ_CLEAR;
      else req = REQ_SPARE5;
    end else begin
      if (roll < 25) req = REQ_INSERT;
      else if (roll < 60) req = REQ_REMOVE;
      else if (roll < 78) req = REQ_GET;
      else if (roll < 90) req = REQ_REPLACE;
      else if (roll < 93) req = REQ_CLEAR;
      else req = REQ_SPARE5;
    end
    // Noise: any code and any position.
    if (req == REQ_SPARE5) begin
      req = REQ_W'($urandom);
      pos = $urandom_range(0, 31);
    end else if ($urandom_range(0, 9) == 0) begin
      pos = (req == REQ_INSERT) ? list_len + 1 : list_len;
    end else if (req == REQ_INSERT) begin
      pos = $urandom_range(0, list_len);
    end else if (list_len == 0) begin
      pos = $urandom_range(0, 2);
    end else begin
      pos = $urandom_range(0, list_len - 1);
    end
    send_item(req, pos, pick_value());
  endtask

  initial begin
    int sent;
    int burst;
    bit fill_phase;

    // Reset once.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items: empty list, edges of the list, spare codes, full list.
    send_item(REQ_GET, 0, 32'h1234_5678);
    send_item(REQ_INSERT, 1, 32'h1);
    send_item(REQ_CLEAR, 0, '0);
    send_item(REQ_INSERT, 0, 32'h7fff_ffff);
    send_item(REQ_INSERT, 0, 32'h8000_0000);
    send_item(REQ_INSERT, 2, '0);
    send_item(REQ_INSERT, 1, '1);
    send_item(REQ_REPLACE, 3, 32'h5555_5555);
    send_item(REQ_GET, 3, '0);
    send_item(REQ_REPLACE, 31, '1);
    send_item(REQ_SPARE5, 4, '1);
    send_item(REQ_SPARE6, 0, '0);
    send_item(REQ_SPARE7, 31, '1);
    while (list_len < DEPTH_DEF) send_item(REQ_INSERT, list_len, $urandom);
    send_item(REQ_INSERT, DEPTH_DEF, 32'haaaa_aaaa);
    send_item(REQ_INSERT, DEPTH_DEF + 1, 32'haaaa_aaaa);
    send_item(REQ_GET, DEPTH_DEF - 1, '0);
    send_item(REQ_REMOVE, DEPTH_DEF - 1, '0);
    send_item(REQ_REMOVE, 0, '0);
    send_item(REQ_REMOVE, 31, '0);
    send_item(REQ_CLEAR, 0, '1);
    send_item(REQ_GET, 0, '0);
    idle_cycles(3);

    // Random items in bursts, alternating between filling and draining.
    sent       = 0;
    fill_phase = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        if (sent % 50 == 49) fill_phase = ~fill_phase;
        send_random_item(fill_phase);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end

    // Drain the outstanding results and give the verdict.
    @(negedge clk_i);
    start <= 1'b0;
    while (results_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("** indexed_insert_remove_list_top: PASSED **");
    end else begin
      $display("** indexed_insert_remove_list_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/iirl_pkg.sv
rtl/core/iirl_ctrl.sv
rtl/core/iirl_dpath.sv
rtl/core/indexed_insert_remove_list_top.sv
tb/indexed_insert_remove_list_checker.sv
tb/tb_indexed_insert_remove_list_top.sv
